FILE: hdl/dbl_pkg.sv
package dbl_pkg;

   // Field and plane formats
   localparam int DEPTH_BITS      = 24;
   localparam int PLANE_BITS      = 32;
   localparam int PLANE_FRAC_BITS = 16;
   localparam int DIST_BITS       = 16;

   // Meters to millimeters
   localparam int MM_SCALE      = 1000;
   localparam int MM_SCALE_BITS = 10;

   // Datapath widths
   localparam int PROD_W = PLANE_BITS + DEPTH_BITS;          // plane * depth
   localparam int DEN_W  = PROD_W + 1;                       // sum of two products
   localparam int NF_W   = 2 * PLANE_BITS;                   // near * far
   localparam int NFM_W  = NF_W + DEPTH_BITS;                // times full scale
   localparam int NUM_W  = NFM_W + MM_SCALE_BITS;            // times 1000
   localparam int A_W    = NUM_W + 2;                        // 2*num + den
   localparam int B_W    = DEN_W + PLANE_FRAC_BITS + 1;      // 2*den
   localparam int REM_W  = B_W + DIST_BITS;                  // remainder once in range

   // Pipeline shape: four front stages, range check, one stage per quotient bit, output
   localparam int FRONT_STAGES = 5;
   localparam int PIPE_LATENCY = FRONT_STAGES + DIST_BITS + 1;

   localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = '1;
   localparam logic [DIST_BITS-1:0]  DIST_MAX   = '1;

   // Register file
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_NEAR_CLIP = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FAR_CLIP  = 1'd1;
   localparam logic [PLANE_BITS-1:0] NEAR_CLIP_RESET = 32'd6554;
   localparam logic [PLANE_BITS-1:0] FAR_CLIP_RESET  = 32'd655360;

   typedef logic [PLANE_BITS-1:0] plane_type;

   // Per-item flags that travel with the data
   typedef struct packed {
      logic bg;    // full-scale sample
      logic sat;   // zero denominator, later also out of range
   } flag_type;

endpackage

FILE: hdl/depth_buffer_linearizer.sv
// Pipeline: the result of a sample taken at one clock edge sits on the rsp ports for one
// cycle on rsp_valid after four arithmetic stages, one range check, one stage per
// quotient bit of the 16-bit restoring divider, and the output register.
// Throughput: one sample per clock while busy is low; start may stay high, and the
// receiver cannot stall. Reset: synchronous, clears all valid bits and reloads both
// clip planes; busy is a registered copy of reset, high in the first cycle after it.
module depth_buffer_linearizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [dbl_pkg::DEPTH_BITS-1:0]   req_depth_code,
   output logic                             rsp_valid,
   output logic [dbl_pkg::DIST_BITS-1:0]    rsp_distance_mm,
   output logic                             rsp_is_background,
   output logic                             rsp_saturated,
   input  logic                             csr_write_en,
   input  logic [dbl_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [dbl_pkg::PLANE_BITS-1:0]   csr_wdata
);

   localparam int NS = dbl_pkg::DIST_BITS;

   logic accept;

   // Control and config
   logic busy_ff, busy_in;
   dbl_pkg::plane_type near_ff, near_in, far_ff, far_in;

   // Front stages
   logic [dbl_pkg::DEPTH_BITS-1:0] depth_inv;
   logic                        s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   dbl_pkg::flag_type           s1_flag_ff, s1_flag_in, s2_flag_ff, s3_flag_ff, s3_flag_in;
   dbl_pkg::flag_type           s4_flag_ff;
   logic [dbl_pkg::PROD_W-1:0]  s1_far_ff, s1_far_in, s1_near_ff, s1_near_in;
   logic [dbl_pkg::NF_W-1:0]    s1_nf_ff, s1_nf_in;
   logic [dbl_pkg::DEN_W-1:0]   s2_den_ff, s2_den_in, s3_den_ff;
   logic [dbl_pkg::NFM_W-1:0]   s2_nfm_ff, s2_nfm_in;
   logic [dbl_pkg::NUM_W-1:0]   s3_num_ff, s3_num_in;
   logic [dbl_pkg::A_W-1:0]     s4_a_ff, s4_a_in;
   logic [dbl_pkg::B_W-1:0]     s4_b_ff, s4_b_in;

   // Divider stages; index 0 is loaded by the range check
   logic                        div_valid_ff [NS+1];
   dbl_pkg::flag_type           div_flag_ff  [NS+1];
   logic [dbl_pkg::REM_W-1:0]   div_rem_ff   [NS+1];
   logic [dbl_pkg::B_W-1:0]     div_b_ff     [NS+1];
   logic [NS-1:0]               div_q_ff     [NS+1];
   dbl_pkg::flag_type           chk_flag_in;

   // Output register
   logic                        rsp_valid_ff;
   logic [NS-1:0]               rsp_dist_ff, rsp_dist_in;
   logic                        rsp_bg_ff, rsp_sat_ff, rsp_sat_in;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // Busy only around reset
   assign busy_in = reset;

   // Config writes
   always_comb begin
      near_in = near_ff;
      far_in  = far_ff;
      if (csr_write_en) begin
         case (csr_index)
            dbl_pkg::CSR_NEAR_CLIP: near_in = csr_wdata;
            dbl_pkg::CSR_FAR_CLIP:  far_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
      if (reset) begin
         near_ff <= dbl_pkg::NEAR_CLIP_RESET;
         far_ff  <= dbl_pkg::FAR_CLIP_RESET;
      end else begin
         near_ff <= near_in;
         far_ff  <= far_in;
      end
   end

   // Stage 1: the three plane products; full scale minus d is just ~d
   always_comb begin
      depth_inv      = ~req_depth_code;
      s1_far_in      = dbl_pkg::PROD_W'(far_ff) * dbl_pkg::PROD_W'(depth_inv);
      s1_near_in     = dbl_pkg::PROD_W'(near_ff) * dbl_pkg::PROD_W'(req_depth_code);
      s1_nf_in       = dbl_pkg::NF_W'(near_ff) * dbl_pkg::NF_W'(far_ff);
      s1_flag_in.bg  = (req_depth_code == dbl_pkg::DEPTH_FULL);
      s1_flag_in.sat = 1'b0;
   end

   // Stage 2: denominator sum, near*far times full scale
   always_comb begin
      s2_den_in = dbl_pkg::DEN_W'(s1_far_ff) + dbl_pkg::DEN_W'(s1_near_ff);
      s2_nfm_in = (dbl_pkg::NFM_W'(s1_nf_ff) << dbl_pkg::DEPTH_BITS)
                  - dbl_pkg::NFM_W'(s1_nf_ff);
   end

   // Stage 3: numerator in mm, zero denominator flag
   always_comb begin
      s3_num_in      = dbl_pkg::NUM_W'(s2_nfm_ff) * dbl_pkg::NUM_W'(dbl_pkg::MM_SCALE);
      s3_flag_in.bg  = s2_flag_ff.bg;
      s3_flag_in.sat = (s2_den_ff == '0);
   end

   // Stage 4: rounding form, floor((2*num + den) / (2*den)) with den scaled by planes
   always_comb begin
      s4_a_in = (dbl_pkg::A_W'(s3_num_ff) << 1)
                + (dbl_pkg::A_W'(s3_den_ff) << dbl_pkg::PLANE_FRAC_BITS);
      s4_b_in = dbl_pkg::B_W'(s3_den_ff) << (dbl_pkg::PLANE_FRAC_BITS + 1);
   end

   // Stage 5: quotient must fit in the output width
   always_comb begin
      chk_flag_in.bg  = s4_flag_ff.bg;
      chk_flag_in.sat = s4_flag_ff.sat || (s4_a_ff >= (dbl_pkg::A_W'(s4_b_ff) << NS));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         s4_valid_ff     <= 1'b0;
         div_valid_ff[0] <= 1'b0;
      end else begin
         s1_valid_ff     <= accept;
         s2_valid_ff     <= s1_valid_ff;
         s3_valid_ff     <= s2_valid_ff;
         s4_valid_ff     <= s3_valid_ff;
         div_valid_ff[0] <= s4_valid_ff;
      end
      s1_far_ff      <= s1_far_in;
      s1_near_ff     <= s1_near_in;
      s1_nf_ff       <= s1_nf_in;
      s1_flag_ff     <= s1_flag_in;
      s2_den_ff      <= s2_den_in;
      s2_nfm_ff      <= s2_nfm_in;
      s2_flag_ff     <= s1_flag_ff;
      s3_num_ff      <= s3_num_in;
      s3_den_ff      <= s2_den_ff;
      s3_flag_ff     <= s3_flag_in;
      s4_a_ff        <= s4_a_in;
      s4_b_ff        <= s4_b_in;
      s4_flag_ff     <= s3_flag_ff;
      // in-range items satisfy a < b << NS, so the remainder fits REM_W
      div_rem_ff[0]  <= s4_a_ff[dbl_pkg::REM_W-1:0];
      div_b_ff[0]    <= s4_b_ff;
      div_q_ff[0]    <= '0;
      div_flag_ff[0] <= chk_flag_in;
   end

   // Restoring divider, one quotient bit per stage, MSB first
   for (genvar j = 0; j < NS; j++) begin : g_div
      localparam int QBIT = NS - 1 - j;
      logic [dbl_pkg::REM_W-1:0] trial;
      logic                      take;
      logic [dbl_pkg::REM_W-1:0] rem_in;
      logic [NS-1:0]             q_in;

      always_comb begin
         trial  = dbl_pkg::REM_W'(div_b_ff[j]) << QBIT;
         take   = (div_rem_ff[j] >= trial);
         rem_in = take ? (div_rem_ff[j] - trial) : div_rem_ff[j];
         q_in   = div_q_ff[j];
         q_in[QBIT] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_valid_ff[j+1] <= 1'b0;
         end else begin
            div_valid_ff[j+1] <= div_valid_ff[j];
         end
         div_rem_ff[j+1]  <= rem_in;
         div_b_ff[j+1]    <= div_b_ff[j];
         div_q_ff[j+1]    <= q_in;
         div_flag_ff[j+1] <= div_flag_ff[j];
      end
   end

   // Output: background wins, then clamp
   always_comb begin
      rsp_sat_in = !div_flag_ff[NS].bg && div_flag_ff[NS].sat;
      if (div_flag_ff[NS].bg) begin
         rsp_dist_in = '0;
      end else if (div_flag_ff[NS].sat) begin
         rsp_dist_in = dbl_pkg::DIST_MAX;
      end else begin
         rsp_dist_in = div_q_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid_ff[NS];
      end
      rsp_dist_ff <= rsp_dist_in;
      rsp_bg_ff   <= div_flag_ff[NS].bg;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_distance_mm   = rsp_dist_ff;
   assign rsp_is_background = rsp_bg_ff;
   assign rsp_saturated     = rsp_sat_ff;

endmodule

FILE: hdl/dbl_checker.sv
module dbl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [dbl_pkg::DEPTH_BITS-1:0] req_depth_code,
   input logic                           rsp_valid,
   input logic [dbl_pkg::DIST_BITS-1:0]  rsp_distance_mm,
   input logic                           rsp_is_background,
   input logic                           rsp_saturated
);

   logic accept;
   assign accept = start && !busy;

   // Every transfer in gives exactly one transfer out, a fixed time later
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(dbl_pkg::PIPE_LATENCY) rsp_valid)
      else $error("accepted sample produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##(dbl_pkg::PIPE_LATENCY) !rsp_valid)
      else $error("result without an accepted sample");

   // Full-scale sample comes back as background
   a_bg_follows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_depth_code == dbl_pkg::DEPTH_FULL)
      |-> ##(dbl_pkg::PIPE_LATENCY) (rsp_is_background && rsp_distance_mm == '0
                                     && !rsp_saturated))
      else $error("background sample not reported as background");

   // Clamped results sit at full scale
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_distance_mm == dbl_pkg::DIST_MAX
                                     && !rsp_is_background)
      else $error("saturated result not at maximum");

endmodule

bind depth_buffer_linearizer dbl_checker u_dbl_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_depth_code    (req_depth_code),
   .rsp_valid         (rsp_valid),
   .rsp_distance_mm   (rsp_distance_mm),
   .rsp_is_background (rsp_is_background),
   .rsp_saturated     (rsp_saturated)
);
